// File: hw/rtl/itt_pkg.sv
// Shared types, codes and helper functions for the three-channel interval timer.
`timescale 1ns / 1ps

package itt_pkg;

    localparam int CountWidth      = 16;
    localparam int MaxChannels     = 3;
    localparam int NumChannelsDflt = 3;

    localparam int InDataWidth  = 16;
    localparam int OutDataWidth = 8;

    typedef logic [CountWidth-1:0] count_t;

    // Command codes carried in the input tuser bit.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Port offset of the control word port.
    localparam logic [1:0] PORT_CONTROL = 2'd3;

    // Access modes from the control word.
    localparam logic [1:0] ACC_LATCH    = 2'd0;
    localparam logic [1:0] ACC_LOW      = 2'd1;
    localparam logic [1:0] ACC_HIGH     = 2'd2;
    localparam logic [1:0] ACC_LOW_HIGH = 2'd3;

    // Effective operating modes after aliasing.
    localparam logic [1:0] MODE_TERMINAL = 2'd0;
    localparam logic [1:0] MODE_RATE     = 2'd2;
    localparam logic [1:0] MODE_SQUARE   = 2'd3;

    // One accepted word as seen by a single channel.
    typedef struct packed {
        logic       tick;
        logic       ctrl_wr;
        logic       data_wr;
        logic [7:0] wbyte;
    } itt_chan_req_t;

    // Modes 2 and 3 (and their aliases 6 and 7) stay; everything else acts as mode 0.
    function automatic logic [1:0] effective_mode(input logic [2:0] m);
        logic [1:0] low2;
        low2 = m[1:0];
        if (low2 == MODE_RATE || low2 == MODE_SQUARE)
            return low2;
        return MODE_TERMINAL;
    endfunction

    // Counter start value for a square-wave half period entered with the given level.
    function automatic count_t square_start(input count_t n, input logic level);
        if (!n[0])
            return n;
        if (level)
            return n + count_t'(1);
        if (n == count_t'(1))
            return count_t'(2);
        return n - count_t'(1);
    endfunction

endpackage

// File: hw/rtl/itt_channel.sv
// One timer channel: its programming registers, down counter and output level.
`timescale 1ns / 1ps

module itt_channel
    import itt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  itt_chan_req_t req,
    output logic          level,
    output logic          level_next
);

    count_t     counter_reg, counter_next;
    count_t     reload_reg, reload_next;
    logic [1:0] mode_reg, mode_next;
    logic [1:0] access_reg, access_next;
    logic       high_next_reg, high_next_next;
    logic [7:0] low_hold_reg, low_hold_next;
    logic       pending_reg, pending_next;
    logic       counting_reg, counting_next;
    logic       level_reg, level_nxt;

    count_t dec1;
    count_t dec2;
    logic   toggled;

    assign dec1    = counter_reg - count_t'(1);
    assign dec2    = counter_reg - count_t'(2);
    assign toggled = ~level_reg;

    always_comb
    begin
        counter_next   = counter_reg;
        reload_next    = reload_reg;
        mode_next      = mode_reg;
        access_next    = access_reg;
        high_next_next = high_next_reg;
        low_hold_next  = low_hold_reg;
        pending_next   = pending_reg;
        counting_next  = counting_reg;
        level_nxt      = level_reg;

        if (req.tick)
        begin
            if (pending_reg)
            begin
                pending_next  = 1'b0;
                counting_next = 1'b1;
                if (mode_reg == MODE_SQUARE)
                    counter_next = square_start(reload_reg, level_reg);
                else
                    counter_next = reload_reg;
            end
            else if (counting_reg)
            begin
                case (mode_reg)
                    MODE_RATE:
                    begin
                        if (dec1 == '0)
                        begin
                            counter_next = reload_reg;
                            level_nxt    = 1'b1;
                        end
                        else
                        begin
                            counter_next = dec1;
                            level_nxt    = (dec1 != count_t'(1));
                        end
                    end
                    MODE_SQUARE:
                    begin
                        if (dec2 == '0)
                        begin
                            level_nxt    = toggled;
                            counter_next = square_start(reload_reg, toggled);
                        end
                        else
                            counter_next = dec2;
                    end
                    default:
                    begin
                        counter_next = dec1;
                        if (dec1 == '0)
                            level_nxt = 1'b1;
                    end
                endcase
            end
        end
        else if (req.ctrl_wr)
        begin
            mode_next      = effective_mode(req.wbyte[3:1]);
            access_next    = req.wbyte[5:4];
            high_next_next = 1'b0;
            pending_next   = 1'b0;
            counting_next  = 1'b0;
            level_nxt      = (effective_mode(req.wbyte[3:1]) != MODE_TERMINAL);
        end
        else if (req.data_wr)
        begin
            case (access_reg)
                ACC_LOW:
                begin
                    reload_next  = {8'd0, req.wbyte};
                    pending_next = 1'b1;
                end
                ACC_HIGH:
                begin
                    reload_next  = {req.wbyte, 8'd0};
                    pending_next = 1'b1;
                end
                default:
                begin
                    if (!high_next_reg)
                    begin
                        low_hold_next  = req.wbyte;
                        high_next_next = 1'b1;
                    end
                    else
                    begin
                        reload_next    = {req.wbyte, low_hold_reg};
                        high_next_next = 1'b0;
                        pending_next   = 1'b1;
                    end
                end
            endcase
            // A completed count in terminal-count mode pulls the output low.
            if (pending_next && !pending_reg && mode_reg == MODE_TERMINAL)
                level_nxt = 1'b0;
            else if (pending_next && mode_reg == MODE_TERMINAL
                     && (access_reg != ACC_LOW_HIGH || high_next_reg))
                level_nxt = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg   <= '0;
            reload_reg    <= '0;
            mode_reg      <= MODE_TERMINAL;
            access_reg    <= ACC_LOW_HIGH;
            high_next_reg <= 1'b0;
            low_hold_reg  <= '0;
            pending_reg   <= 1'b0;
            counting_reg  <= 1'b0;
            level_reg     <= 1'b0;
        end
        else
        begin
            counter_reg   <= counter_next;
            reload_reg    <= reload_next;
            mode_reg      <= mode_next;
            access_reg    <= access_next;
            high_next_reg <= high_next_next;
            low_hold_reg  <= low_hold_next;
            pending_reg   <= pending_next;
            counting_reg  <= counting_next;
            level_reg     <= level_nxt;
        end
    end

    assign level      = level_reg;
    assign level_next = level_nxt;

endmodule

// File: hw/rtl/interval_timer_three_channel.sv
// Top level of the three-channel interval timer: input register, channels, result register.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake                    Contents
//  s_axis    in         s_axis_tvalid/s_axis_tready  tuser: tick flag; tdata: port, byte
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata: output levels, interrupt pulse
//
//  The block takes one word per clock cycle, unless the result register is stalled,
//  and returns one result word for each. A word is held in the input register; the
//  channel update is done while it moves into the result register.
//  A stalled result register holds the input register, which in turn drops s_axis_tready.
//  Reset clears all channel state: modes to terminal count, access to low then high.

module interval_timer_three_channel
    import itt_pkg::*;
#(
    parameter int NUM_CHANNELS = NumChannelsDflt
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // [1:0] port_offset, [9:2] write_byte, [15:10] zero
    input  logic [InDataWidth-1:0]  s_axis_tdata,
    // [0] command (0 = bus write, 1 = input clock tick)
    input  logic                    s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // [2:0] out_levels, [3] irq_pulse, [7:4] zero
    output logic [OutDataWidth-1:0] m_axis_tdata
);

    // Input register. Only the ten meaningful bits of tdata are kept.
    logic       in_valid_reg, in_valid_next;
    logic       in_cmd_reg;
    logic [1:0] in_port_reg;
    logic [7:0] in_byte_reg;

    // Result register.
    logic                    out_valid_reg, out_valid_next;
    logic [OutDataWidth-1:0] out_data_reg;

    logic                   advance;
    logic                   in_take;
    logic [MaxChannels-1:0] levels_now;
    logic [MaxChannels-1:0] levels_new;
    logic                   irq;

    // A word moves on when the result register is empty or being emptied.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign in_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    // Each channel sees the word only in the cycle it advances.
    for (genvar c = 0; c < MaxChannels; c++)
    begin : g_chan
        if (c < NUM_CHANNELS)
        begin : g_on
            itt_chan_req_t req;

            always_comb
            begin
                req.wbyte   = in_byte_reg;
                req.tick    = advance && (in_cmd_reg == CMD_TICK);
                req.ctrl_wr = advance && (in_cmd_reg == CMD_WRITE)
                              && (in_port_reg == PORT_CONTROL)
                              && (in_byte_reg[7:6] == 2'(c))
                              && (in_byte_reg[5:4] != ACC_LATCH);
                req.data_wr = advance && (in_cmd_reg == CMD_WRITE)
                              && (in_port_reg == 2'(c));
            end

            itt_channel u_chan (
                .clk        (clk),
                .rst_n      (rst_n),
                .req        (req),
                .level      (levels_now[c]),
                .level_next (levels_new[c])
            );
        end
        else
        begin : g_off
            assign levels_now[c] = 1'b0;
            assign levels_new[c] = 1'b0;
        end
    end

    // Interrupt on a rising edge of channel 0 caused by a tick.
    assign irq = (in_cmd_reg == CMD_TICK) && !levels_now[0] && levels_new[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_cmd_reg  <= s_axis_tuser;
            in_port_reg <= s_axis_tdata[1:0];
            in_byte_reg <= s_axis_tdata[9:2];
        end
        if (advance)
            out_data_reg <= {4'd0, irq, levels_new};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
